FILE: hdl/bpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_pkg
// Types, opcode patterns and class codes for the 16-bit branch predecoder.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int ADDR_WIDTH = 32;
  // addresses wrap at ADDR_WIDTH and are then cut to 32 bits
  localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam int PADDR_WIDTH = 3;
  localparam logic [0:0] REG_MSB_FIRST = 1'd0;

  // control-flow classes
  localparam logic [3:0] CLS_ILL   = 4'd0;
  localparam logic [3:0] CLS_JMP   = 4'd1;
  localparam logic [3:0] CLS_MJMP  = 4'd2;
  localparam logic [3:0] CLS_CALL  = 4'd3;
  localparam logic [3:0] CLS_ICALL = 4'd4;
  localparam logic [3:0] CLS_UCALL = 4'd5;
  localparam logic [3:0] CLS_CJMP  = 4'd6;
  localparam logic [3:0] CLS_RET   = 4'd7;
  localparam logic [3:0] CLS_SWI   = 4'd8;
  localparam logic [3:0] CLS_NOP   = 4'd9;
  localparam logic [3:0] CLS_LOAD  = 4'd10;
  localparam logic [3:0] CLS_STORE = 4'd11;
  localparam logic [3:0] CLS_ADD   = 4'd12;
  localparam logic [3:0] CLS_IO    = 4'd13;
  localparam logic [3:0] CLS_UNK   = 4'd14;

  // sizes in bytes
  localparam logic [3:0] SIZE_NONE = 4'd0;
  localparam logic [3:0] SIZE_WORD = 4'd2;
  localparam logic [3:0] SIZE_ENTR = 4'd4;
  localparam logic [3:0] SIZE_INIT = 4'd14;

  // field masks
  localparam logic [15:0] MASK_TOP5 = 16'hF800;
  localparam logic [15:0] MASK_TOP8 = 16'hFF00;
  localparam logic [15:0] MASK_TOP9 = 16'hFF80;
  localparam logic [15:0] MASK_TOP7 = 16'hFE00;
  localparam logic [15:0] MASK_TOP10 = 16'hFFC0;
  localparam logic [15:0] MASK_TOP13 = 16'hFFF8;
  localparam logic [15:0] MASK_BITS76 = 16'h00C0;

  // opcode patterns
  localparam logic [15:0] OP_JMP    = 16'hA800;
  localparam logic [15:0] OP_CALL   = 16'hB800;
  localparam logic [15:0] OP_CJMP   = 16'hB000;
  localparam logic [15:0] OP_ENTR   = 16'hC05D;
  localparam logic [15:0] OP_INIT   = 16'hC05C;
  localparam logic [15:0] OP_RET_A  = 16'hC09E;
  localparam logic [15:0] OP_RET_B  = 16'hC09F;
  localparam logic [15:0] OP_RET_C  = 16'hCC62;
  localparam logic [15:0] OP_MON    = 16'hD600;
  localparam logic [15:0] OP_SKP_A  = 16'hD10D;
  localparam logic [15:0] OP_NOP_A  = 16'hD200;
  localparam logic [15:0] OP_SKP_B  = 16'hD300;
  localparam logic [15:0] OP_SKP_C  = 16'hD400;
  localparam logic [15:0] OP_SKP_D  = 16'hD500;
  localparam logic [15:0] OP_SKP_E  = 16'hC050;
  localparam logic [15:0] OP_SKP_F  = 16'hC14E;
  localparam logic [15:0] OP_SKP_G  = 16'hC14F;
  localparam logic [15:0] OP_SKP_H  = 16'hC000;
  localparam logic [15:0] OP_SKP_I  = 16'h4000;
  localparam logic [15:0] OP_LOAD   = 16'h4800;
  localparam logic [15:0] OP_STORE  = 16'h0800;
  localparam logic [15:0] OP_ADD_A  = 16'h6000;
  localparam logic [15:0] OP_ADD_B  = 16'h6800;
  localparam logic [15:0] OP_IO_A   = 16'hE000;
  localparam logic [15:0] OP_IO_B   = 16'hE800;
  localparam logic [15:0] OP_SKP_J  = 16'hFA00;
  localparam logic [15:0] OP_NOP_B  = 16'hCFC0;

  localparam logic [2:0] MODE_DIRECT   = 3'd0;
  localparam logic [2:0] MODE_INDIRECT = 3'd2;

  typedef struct packed {
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [31:0] address;
    logic [3:0]  bytes_available;
  } bpd_in_t;

  typedef struct packed {
    logic [3:0]  op_class;
    logic [3:0]  op_size;
    logic        jump_valid;
    logic [31:0] jump_address;
    logic        fail_valid;
    logic [31:0] fail_address;
    logic        ends_block;
    logic        monitor_valid;
    logic [7:0]  monitor_number;
  } bpd_out_t;

  typedef struct packed {
    logic msb_first;
  } bpd_cfg_t;

endpackage

FILE: hdl/bpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_if
// Valid/ready channels for instruction items and predecode result items.
// ----------------------------------------------------------------------------
interface bpd_in_if;
  logic             valid;
  logic             ready;
  bpd_pkg::bpd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpd_out_if;
  logic              valid;
  logic              ready;
  bpd_pkg::bpd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/branch_predecode_16bit_unit.sv
`timescale 1ns / 1ps
// path: item accept, input register, single-pass decode, result register, result accept
// throughput: one item per cycle while result.ready holds, set by the single-pass decode
// reset: rst (synchronous, active high) empties both stages and clears msb_first to 0
// ----------------------------------------------------------------------------
// branch_predecode_16bit_unit
// Control-flow predecode of one 16-bit instruction per item, with an APB
// register selecting the byte order of the two instruction bytes.
// ----------------------------------------------------------------------------
module branch_predecode_16bit_unit (
  input  logic                            clk,
  input  logic                            rst,
  // instruction items in, predecode result items out
  bpd_in_if.sink                          instr,
  bpd_out_if.source                       result,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpd_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bpd_pkg::*;

  bpd_cfg_t cfg;

  // input stage
  logic    s1_valid;
  bpd_in_t s1_data;
  logic    s1_advance;

  // decode result feeding the result register
  bpd_out_t dec_res;

  // result register
  logic     res_valid;
  bpd_out_t res_data;

  bpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the input stage moves on when the result register is empty or being drained
  assign s1_advance  = s1_valid && (!res_valid || result.ready);
  // a new item enters whenever the input stage is empty or moves on this cycle
  assign instr.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.valid && instr.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      s1_data <= instr.data;
    end
  end

  bpd_decode u_decode (
    .item (s1_data),
    .cfg  (cfg),
    .res  (dec_res)
  );

  // result register holds a finished item until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_data <= dec_res;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

endmodule

FILE: hdl/bpd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_cfg_regs
// APB register file holding the byte-order control.
// ----------------------------------------------------------------------------
module bpd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpd_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output bpd_pkg::bpd_cfg_t             cfg
);
  import bpd_pkg::*;

  logic       msb_first;
  logic [0:0] reg_index;

  assign reg_index = paddr[PADDR_WIDTH-1 -: 1];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      msb_first <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_index == REG_MSB_FIRST) begin
      msb_first <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_MSB_FIRST) begin
      prdata = {31'd0, msb_first};
    end
  end

  assign cfg.msb_first = msb_first;

endmodule

FILE: hdl/bpd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_decode
// Combinational predecode of one instruction word into class and targets.
// ----------------------------------------------------------------------------
module bpd_decode (
  input  bpd_pkg::bpd_in_t  item,
  input  bpd_pkg::bpd_cfg_t cfg,
  output bpd_pkg::bpd_out_t res
);
  import bpd_pkg::*;

  logic [15:0] word;
  logic [15:0] top5;
  logic [15:0] top8;
  logic [2:0]  mode;
  logic [31:0] off2;
  logic [31:0] rel_addr;
  logic [31:0] addr_p2;
  logic [31:0] addr_p4;
  logic [31:0] addr_p6;
  logic [31:0] addr_p12;
  logic [31:0] addr_p14;
  logic        skip_grp;
  logic        skip;

  always_comb begin
    word = cfg.msb_first ? {item.byte_first, item.byte_second}
                         : {item.byte_second, item.byte_first};
    top5 = word & MASK_TOP5;
    top8 = word & MASK_TOP8;
    mode = word[10:8];
    // signed word offset scaled to bytes
    off2 = {{23{word[7]}}, word[7:0], 1'b0};
    rel_addr = (item.address + off2) & ADDR_MASK;
    addr_p2  = (item.address + 32'd2) & ADDR_MASK;
    addr_p4  = (item.address + 32'd4) & ADDR_MASK;
    addr_p6  = (item.address + 32'd6) & ADDR_MASK;
    addr_p12 = (item.address + 32'd12) & ADDR_MASK;
    addr_p14 = (item.address + 32'd14) & ADDR_MASK;

    skip_grp = (top8 == OP_SKP_B) || (top8 == OP_SKP_C) ||
               ((word & MASK_TOP9) == OP_SKP_D) ||
               ((word & MASK_TOP13) == OP_SKP_E) ||
               (word == OP_SKP_F) || (word == OP_SKP_G) ||
               ((top5 == OP_SKP_H) && ((word & MASK_BITS76) == 16'h0000)) ||
               (top5 == OP_SKP_I);

    res          = '0;
    res.op_class = CLS_UNK;
    res.op_size  = SIZE_WORD;
    skip         = 1'b0;

    if (item.bytes_available < 4'd2) begin
      res.op_class = CLS_ILL;
      res.op_size  = SIZE_NONE;
    end else if (top5 == OP_JMP) begin
      if (mode == MODE_DIRECT) begin
        res.op_class     = CLS_JMP;
        res.jump_valid   = 1'b1;
        res.jump_address = rel_addr;
      end else begin
        res.op_class = CLS_MJMP;
      end
      res.ends_block = 1'b1;
    end else if (top5 == OP_CALL) begin
      res.fail_valid   = 1'b1;
      res.fail_address = addr_p2;
      if (mode == MODE_DIRECT) begin
        res.op_class     = CLS_CALL;
        res.jump_valid   = 1'b1;
        res.jump_address = rel_addr;
      end else if (mode == MODE_INDIRECT) begin
        res.op_class = CLS_ICALL;
      end else begin
        res.op_class = CLS_UCALL;
      end
    end else if (top5 == OP_CJMP) begin
      res.op_class     = CLS_CJMP;
      res.jump_valid   = 1'b1;
      res.jump_address = rel_addr;
      res.fail_valid   = 1'b1;
      res.fail_address = addr_p2;
    end else if (word == OP_ENTR) begin
      res.op_size = SIZE_ENTR;
      if (item.bytes_available >= 4'd4) begin
        res.op_class     = CLS_CJMP;
        res.jump_valid   = 1'b1;
        res.jump_address = addr_p6;
        res.fail_valid   = 1'b1;
        res.fail_address = addr_p4;
      end
    end else if (word == OP_INIT) begin
      res.op_size = SIZE_INIT;
      if (item.bytes_available >= 4'd14) begin
        res.op_class     = CLS_CJMP;
        res.jump_valid   = 1'b1;
        res.jump_address = addr_p14;
        res.fail_valid   = 1'b1;
        res.fail_address = addr_p12;
      end
    end else if (word == OP_RET_A || word == OP_RET_B || word == OP_RET_C) begin
      res.op_class   = CLS_RET;
      res.ends_block = 1'b1;
    end else if (top8 == OP_MON) begin
      res.op_class       = CLS_SWI;
      res.monitor_valid  = 1'b1;
      res.monitor_number = word[7:0];
      res.ends_block     = (word[7:0] == 8'd0);
    end else if (word == OP_SKP_A) begin
      skip = 1'b1;
    end else if (top8 == OP_NOP_A) begin
      res.op_class   = CLS_NOP;
      res.ends_block = 1'b1;
    end else if (skip_grp) begin
      skip = 1'b1;
    end else if (top5 == OP_LOAD) begin
      res.op_class = CLS_LOAD;
    end else if (top5 == OP_STORE) begin
      res.op_class = CLS_STORE;
    end else if (top5 == OP_ADD_A || top5 == OP_ADD_B) begin
      res.op_class = CLS_ADD;
    end else if (top5 == OP_IO_A || top5 == OP_IO_B) begin
      res.op_class = CLS_IO;
    end else if ((word & MASK_TOP7) == OP_SKP_J) begin
      skip = 1'b1;
    end else if ((word & MASK_TOP10) == OP_NOP_B) begin
      res.op_class = CLS_NOP;
    end

    // skip instructions branch over the next word
    if (skip) begin
      res.op_class     = CLS_CJMP;
      res.jump_valid   = 1'b1;
      res.jump_address = addr_p4;
      res.fail_valid   = 1'b1;
      res.fail_address = addr_p2;
    end
  end

endmodule

FILE: dv/tb_branch_predecode_16bit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_branch_predecode_16bit_unit
// Self-checking bench for the 16-bit branch predecoder. A short table of
// hand-picked instruction words is run first, then opcode-biased random items
// under both byte orders. Each accepted item is predicted in the bench, and
// each result item is checked field by field in arrival order. The sender
// works in bursts and the receiver stalls, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_branch_predecode_16bit_unit;
  import bpd_pkg::*;

  // run limits and shape
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEMS_PER_SET = 430;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT       = 150;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;

  // register index with no register behind it, writes must be ignored
  localparam int REG_SPARE = 1;

  // results that can be read off directly
  localparam bpd_out_t RES_ILLEGAL    = '{op_class: CLS_ILL, op_size: SIZE_NONE, default: '0};
  localparam bpd_out_t RES_ENTR_SHORT = '{op_class: CLS_UNK, op_size: SIZE_ENTR, default: '0};
  localparam bpd_out_t RES_INIT_SHORT = '{op_class: CLS_UNK, op_size: SIZE_INIT, default: '0};

  typedef struct packed {
    bpd_in_t  item_in;
    logic     known;     // 1: res holds the result, else predicted
    bpd_out_t res;
  } directed_row_t;

  // directed instruction words, run little-endian right after reset
  // bytes are in memory order, so the high byte of the word comes second
  localparam directed_row_t DIRECTED [29] = '{
    // short inputs: nothing is decoded
    '{'{8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'd0},  1'b1, RES_ILLEGAL},
    '{'{8'h00, 8'hA8, 32'h0000_1000, 4'd1},  1'b1, RES_ILLEGAL},
    // relative jumps, forward and backward across zero, and one non-direct jump
    '{'{8'h7F, 8'hA8, 32'h0000_0000, 4'd2},  1'b0, '0},
    '{'{8'h80, 8'hA8, 32'h0000_0010, 4'd15}, 1'b0, '0},
    '{'{8'h00, 8'hAF, 32'h8000_0000, 4'd15}, 1'b0, '0},
    // calls in each mode and one conditional jump, return address wraps
    '{'{8'h05, 8'hB8, 32'hFFFF_FFFE, 4'd15}, 1'b0, '0},
    '{'{8'h00, 8'hBA, 32'h1234_5678, 4'd15}, 1'b0, '0},
    '{'{8'h81, 8'hBF, 32'h0000_0000, 4'd15}, 1'b0, '0},
    '{'{8'hFF, 8'hB0, 32'h0000_0000, 4'd15}, 1'b0, '0},
    // multi-word skips, complete and truncated
    '{'{8'h5D, 8'hC0, 32'hFFFF_FFFC, 4'd4},  1'b0, '0},
    '{'{8'h5D, 8'hC0, 32'h0000_2000, 4'd3},  1'b1, RES_ENTR_SHORT},
    '{'{8'h5C, 8'hC0, 32'hFFFF_FFF8, 4'd14}, 1'b0, '0},
    '{'{8'h5C, 8'hC0, 32'h0000_3000, 4'd13}, 1'b1, RES_INIT_SHORT},
    // returns and monitor calls
    '{'{8'h9F, 8'hC0, 32'hFFFF_FFFF, 4'd15}, 1'b0, '0},
    '{'{8'h62, 8'hCC, 32'h0000_0100, 4'd15}, 1'b0, '0},
    '{'{8'h00, 8'hD6, 32'h0000_0200, 4'd15}, 1'b0, '0},
    '{'{8'hFF, 8'hD6, 32'h0000_0300, 4'd15}, 1'b0, '0},
    // skip family and the rest of the classes
    '{'{8'h0D, 8'hD1, 32'hFFFF_FFFC, 4'd15}, 1'b0, '0},
    '{'{8'hAA, 8'hD2, 32'h0000_0400, 4'd15}, 1'b0, '0},
    '{'{8'h7F, 8'hD5, 32'h0000_0500, 4'd15}, 1'b0, '0},
    '{'{8'h4E, 8'hC1, 32'h0000_0600, 4'd15}, 1'b0, '0},
    '{'{8'h00, 8'h48, 32'h0000_0700, 4'd15}, 1'b0, '0},
    '{'{8'hFF, 8'h0F, 32'h0000_0800, 4'd15}, 1'b0, '0},
    '{'{8'h00, 8'h68, 32'h0000_0900, 4'd15}, 1'b0, '0},
    '{'{8'hFF, 8'hE7, 32'h0000_0A00, 4'd15}, 1'b0, '0},
    '{'{8'hFF, 8'hFB, 32'hFFFF_FFFE, 4'd15}, 1'b0, '0},
    '{'{8'hFF, 8'hCF, 32'h0000_0B00, 4'd15}, 1'b0, '0},
    '{'{8'h00, 8'h00, 32'h0000_0C00, 4'd15}, 1'b0, '0},
    '{'{8'hFF, 8'hFF, 32'h0000_0D00, 4'd15}, 1'b0, '0}
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_WIDTH-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bpd_in_if  instr_ch ();
  bpd_out_if result_ch ();

  branch_predecode_16bit_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .instr   (instr_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // bench copy of the byte-order register
  logic cfg_msb_first;

  // predicted result items, oldest first
  bpd_out_t predicted_results [$];
  bpd_out_t oldest_prediction;

  int n_cycles;
  int n_results;
  int n_mismatches;
  int burst_left;

  // receiver stall state
  logic [15:0] ready_pattern;
  int pattern_age;
  int hold_left;
  bit hold_done;

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor: class, size and targets of one instruction item
  // --------------------------------------------------------------------------
  function automatic bpd_out_t predecode_instr(input bpd_in_t ins, input logic msb_first);
    bpd_out_t r;
    logic [15:0] w;
    logic [15:0] top5;
    logic [15:0] top8;
    logic [2:0] mode;
    logic [31:0] rel;
    logic [31:0] next2;
    logic skip;

    r = '0;
    r.op_class = CLS_UNK;
    r.op_size = SIZE_WORD;
    skip = 1'b0;
    // fewer than two bytes: nothing else is looked at
    if (ins.bytes_available < 4'd2) begin
      r.op_class = CLS_ILL;
      r.op_size = SIZE_NONE;
      return r;
    end
    w = msb_first ? {ins.byte_first, ins.byte_second} : {ins.byte_second, ins.byte_first};
    top5 = w & MASK_TOP5;
    top8 = w & MASK_TOP8;
    mode = w[10:8];
    // twice the signed low byte, wrapped at the address width
    rel = (ins.address + {{23{w[7]}}, w[7:0], 1'b0}) & ADDR_MASK;
    next2 = (ins.address + 32'd2) & ADDR_MASK;

    if (top5 == OP_JMP) begin
      if (mode == MODE_DIRECT) begin
        r.op_class = CLS_JMP;
        r.jump_valid = 1'b1;
        r.jump_address = rel;
      end else begin
        r.op_class = CLS_MJMP;
      end
      r.ends_block = 1'b1;
    end else if (top5 == OP_CALL) begin
      r.fail_valid = 1'b1;
      r.fail_address = next2;
      if (mode == MODE_DIRECT) begin
        r.op_class = CLS_CALL;
        r.jump_valid = 1'b1;
        r.jump_address = rel;
      end else if (mode == MODE_INDIRECT) begin
        r.op_class = CLS_ICALL;
      end else begin
        r.op_class = CLS_UCALL;
      end
    end else if (top5 == OP_CJMP) begin
      r.op_class = CLS_CJMP;
      r.jump_valid = 1'b1;
      r.jump_address = rel;
      r.fail_valid = 1'b1;
      r.fail_address = next2;
    end else if (w == OP_ENTR) begin
      // stays unknown when the whole instruction is not readable
      r.op_size = SIZE_ENTR;
      if (ins.bytes_available >= SIZE_ENTR) begin
        r.op_class = CLS_CJMP;
        r.jump_valid = 1'b1;
        r.jump_address = (ins.address + 32'd6) & ADDR_MASK;
        r.fail_valid = 1'b1;
        r.fail_address = (ins.address + 32'd4) & ADDR_MASK;
      end
    end else if (w == OP_INIT) begin
      r.op_size = SIZE_INIT;
      if (ins.bytes_available >= SIZE_INIT) begin
        r.op_class = CLS_CJMP;
        r.jump_valid = 1'b1;
        r.jump_address = (ins.address + 32'd14) & ADDR_MASK;
        r.fail_valid = 1'b1;
        r.fail_address = (ins.address + 32'd12) & ADDR_MASK;
      end
    end else if (w == OP_RET_A || w == OP_RET_B || w == OP_RET_C) begin
      r.op_class = CLS_RET;
      r.ends_block = 1'b1;
    end else if (top8 == OP_MON) begin
      // monitor call zero does not come back
      r.op_class = CLS_SWI;
      r.monitor_valid = 1'b1;
      r.monitor_number = w[7:0];
      r.ends_block = (w[7:0] == 8'd0);
    end else if (w == OP_SKP_A) begin
      skip = 1'b1;
    end else if (top8 == OP_NOP_A) begin
      r.op_class = CLS_NOP;
      r.ends_block = 1'b1;
    end else if (top8 == OP_SKP_B || top8 == OP_SKP_C
                 || (w & MASK_TOP9) == OP_SKP_D
                 || (w & MASK_TOP13) == OP_SKP_E
                 || w == OP_SKP_F || w == OP_SKP_G
                 || (top5 == OP_SKP_H && (w & MASK_BITS76) == 16'd0)
                 || top5 == OP_SKP_I) begin
      skip = 1'b1;
    end else if (top5 == OP_LOAD) begin
      r.op_class = CLS_LOAD;
    end else if (top5 == OP_STORE) begin
      r.op_class = CLS_STORE;
    end else if (top5 == OP_ADD_A || top5 == OP_ADD_B) begin
      r.op_class = CLS_ADD;
    end else if (top5 == OP_IO_A || top5 == OP_IO_B) begin
      r.op_class = CLS_IO;
    end else if ((w & MASK_TOP7) == OP_SKP_J) begin
      skip = 1'b1;
    end else if ((w & MASK_TOP10) == OP_NOP_B) begin
      r.op_class = CLS_NOP;
    end

    // skips jump over the next word
    if (skip) begin
      r.op_class = CLS_CJMP;
      r.jump_valid = 1'b1;
      r.jump_address = (ins.address + 32'd4) & ADDR_MASK;
      r.fail_valid = 1'b1;
      r.fail_address = next2;
    end
    return r;
  endfunction

  // instruction word biased toward the decoded opcode groups
  function automatic logic [15:0] random_opcode_word();
    logic [15:0] r;

    r = 16'($urandom);
    case ($urandom_range(0, 31))
      0:  return OP_JMP | 16'(r[7:0]);
      1:  return OP_JMP | 16'(r[10:0]);
      2:  return OP_CALL | 16'(r[7:0]);
      3:  return OP_CALL | 16'(r[10:0]);
      4:  return OP_CJMP | 16'(r[10:0]);
      5:  return OP_ENTR;
      6:  return OP_INIT;
      7:  return r[0] ? OP_RET_A : OP_RET_B;
      8:  return OP_RET_C;
      9:  return OP_MON | 16'(r[7:0]);
      10: return OP_MON;
      11: return OP_SKP_A;
      12: return OP_NOP_A | 16'(r[7:0]);
      13: return OP_SKP_B | 16'(r[7:0]);
      14: return OP_SKP_C | 16'(r[7:0]);
      15: return OP_SKP_D | 16'(r[7:0]);
      16: return OP_SKP_E | 16'(r[3:0]);
      17: return r[0] ? OP_SKP_F : OP_SKP_G;
      18: return OP_SKP_H | (16'(r[10:0]) & ~MASK_BITS76);
      19: return OP_SKP_H | 16'(r[11:0]);
      20: return OP_SKP_I | 16'(r[10:0]);
      21: return OP_LOAD | 16'(r[10:0]);
      22: return OP_STORE | 16'(r[10:0]);
      23: return OP_ADD_A | 16'(r[11:0]);
      24: return OP_IO_A | 16'(r[11:0]);
      25: return OP_SKP_J | 16'(r[8:0]);
      26: return OP_NOP_B | 16'(r[5:0]);
      default: return r;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // field compare, first few mismatches printed
  // --------------------------------------------------------------------------
  task automatic check_field(input string fname, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      n_mismatches++;
      if (n_mismatches <= MAX_REPORTS)
        $display("mismatch: %s at result %0d, expected %h, got %h",
                 fname, n_results, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // config port: setup cycle, access cycle, then back to idle
  // all tasks start and end at a falling edge
  // --------------------------------------------------------------------------
  task automatic apb_write(input int idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_WIDTH'(idx * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // only index 0 holds a register
    if (idx == int'(REG_MSB_FIRST))
      cfg_msb_first = value[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_check_byte_order();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_WIDTH'(int'(REG_MSB_FIRST) * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("msb_first readback", prdata, {31'd0, cfg_msb_first});
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // sender: offer one item, predict it on accept, then maybe open a gap
  // valid stays high across a burst, so it is only driven once per edge
  // --------------------------------------------------------------------------
  task automatic offer_instr(input bpd_in_t item, input logic known, input bpd_out_t res);
    instr_ch.valid <= 1'b1;
    instr_ch.data <= item;
    do @(posedge clk); while (!instr_ch.ready);
    predicted_results.push_back(known ? res : predecode_instr(item, cfg_msb_first));
    @(negedge clk);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      instr_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
    end
  endtask

  // random instruction items under the current byte order
  task automatic decode_random_items(input int count);
    bpd_in_t item;
    logic [15:0] w;
    int sel;

    for (int k = 0; k < count; k++) begin
      w = random_opcode_word();
      // lay the word out in memory order so the intended opcode arrives
      if (cfg_msb_first)
        {item.byte_first, item.byte_second} = w;
      else
        {item.byte_second, item.byte_first} = w;
      // addresses near both ends of the range to catch wrapping
      case ($urandom_range(0, 7))
        0: item.address = {24'hFF_FFFF, 8'($urandom)};
        1: item.address = {24'h00_0000, 8'($urandom)};
        default: item.address = $urandom;
      endcase
      // mostly complete fetches, some truncated ones, a few illegal
      sel = $urandom_range(0, 9);
      if (sel == 0)
        item.bytes_available = 4'($urandom_range(0, 1));
      else if (sel <= 3)
        item.bytes_available = 4'($urandom_range(2, 15));
      else
        item.bytes_available = 4'($urandom_range(14, 15));
      offer_instr(item, 1'b0, '0);
    end
  endtask

  // idle point between phases: input dropped, all results back
  task automatic drain_results();
    if (instr_ch.valid)
      instr_ch.valid <= 1'b0;
    while (predicted_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // receiver: rotating stall pattern, reshuffled whenever pattern_age wraps, plus one
  // long hold-off that lets the block fill up and push back on the sender
  // --------------------------------------------------------------------------
  initial begin
    result_ch.ready = 1'b0;
    ready_pattern = 16'hFFFF;
    pattern_age = 0;
    hold_left = 0;
    hold_done = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (!hold_done && n_results >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        pattern_age++;
        if (pattern_age == 64) begin
          pattern_age = 0;
          // always-ready stretches between stalling ones
          ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'd1);
        end
      end
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // result checking against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (predicted_results.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= MAX_REPORTS)
          $display("mismatch: result %0d arrived with no item pending", n_results);
      end else begin
        oldest_prediction = predicted_results.pop_front();
        check_field("op_class", 32'(result_ch.data.op_class), 32'(oldest_prediction.op_class));
        check_field("op_size", 32'(result_ch.data.op_size), 32'(oldest_prediction.op_size));
        check_field("jump_valid", 32'(result_ch.data.jump_valid),
                    32'(oldest_prediction.jump_valid));
        check_field("jump_address", result_ch.data.jump_address,
                    oldest_prediction.jump_address);
        check_field("fail_valid", 32'(result_ch.data.fail_valid),
                    32'(oldest_prediction.fail_valid));
        check_field("fail_address", result_ch.data.fail_address,
                    oldest_prediction.fail_address);
        check_field("ends_block", 32'(result_ch.data.ends_block),
                    32'(oldest_prediction.ends_block));
        check_field("monitor_valid", 32'(result_ch.data.monitor_valid),
                    32'(oldest_prediction.monitor_valid));
        check_field("monitor_number", 32'(result_ch.data.monitor_number),
                    32'(oldest_prediction.monitor_number));
      end
      n_results++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    instr_ch.valid = 1'b0;
    instr_ch.data = '0;
    cfg_msb_first = 1'b0;
    n_cycles = 0;
    n_results = 0;
    n_mismatches = 0;
    burst_left = 1;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value of the byte order, then the directed table little-endian
    apb_check_byte_order();
    foreach (DIRECTED[i])
      offer_instr(DIRECTED[i].item_in, DIRECTED[i].known, DIRECTED[i].res);
    drain_results();

    // big-endian, upper data bits set and ignored
    apb_write(int'(REG_MSB_FIRST), 32'hFFFF_FFFF);
    apb_check_byte_order();
    decode_random_items(ITEMS_PER_SET);
    drain_results();

    // write to an unused index must leave the byte order alone
    apb_write(REG_SPARE, 32'h0000_0000);
    apb_check_byte_order();
    decode_random_items(ITEMS_PER_SET);
    drain_results();

    // back to little-endian
    apb_write(int'(REG_MSB_FIRST), 32'hFFFF_FFFE);
    apb_check_byte_order();
    decode_random_items(ITEMS_PER_SET);
    drain_results();

    // and big-endian once more with a plain one
    apb_write(int'(REG_MSB_FIRST), 32'h0000_0001);
    apb_check_byte_order();
    decode_random_items(ITEMS_PER_SET);
    drain_results();

    if (n_mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
